@@ src/line_rasterizer_assert.svh @@
// assertion helpers for the line rasterizer, clocked on the rising edge,
// disabled while reset is asserted
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

// same-cycle implication
`define LR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line rasterizer check failed");

// next-cycle implication
`define LR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line rasterizer check failed");

`endif

@@ src/lr_pkg.sv @@
package lr_pkg;

  localparam int PIX_W    = 12;
  localparam int INT_W    = 8;
  localparam int FRAC_W   = 8;
  localparam int QUO_W    = 9;
  localparam int GRAD_W   = QUO_W + 1;
  localparam int PIDX_W   = 2;

  localparam logic [INT_W-1:0] INT_FULL  = 8'hFF;
  localparam logic [INT_W-1:0] DIAG_CORR = 8'd40;

  // pixel slot within one column
  localparam logic [PIDX_W-1:0] PIX_MAIN  = 2'd0;
  localparam logic [PIDX_W-1:0] PIX_ABOVE = 2'd1;
  localparam logic [PIDX_W-1:0] PIX_BELOW = 2'd2;

  typedef enum logic [1:0] {
    KIND_RUN  = 2'd0,
    KIND_BRES = 2'd1,
    KIND_WU   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

endpackage

@@ src/lr_if.sv @@
interface lr_in_if
  import lr_pkg::*;
#(
  parameter int COORD_WIDTH = 10
) ();
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [COORD_WIDTH-1:0] x_start;
  logic [COORD_WIDTH-1:0] y_start;
  logic [COORD_WIDTH-1:0] x_end;
  logic [COORD_WIDTH-1:0] y_end;
  logic                   use_background;

  modport source (output valid, mode, x_start, y_start, x_end, y_end, use_background,
                  input ready);
  modport sink (input valid, mode, x_start, y_start, x_end, y_end, use_background,
                output ready);
endinterface

interface lr_out_if
  import lr_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;
  logic [INT_W-1:0]        intensity;
  logic                    paint_background;
  logic                    pixel_valid;
  logic                    line_end;
  logic                    last;

  modport source (output valid, pixel_x, pixel_y, intensity, paint_background,
                  pixel_valid, line_end, last, input ready);
  modport sink (input valid, pixel_x, pixel_y, intensity, paint_background,
                pixel_valid, line_end, last, output ready);
endinterface

interface lr_cfg_if
  import lr_pkg::*;
();
  logic valid;
  logic ready;
  logic antialias_enable;

  modport source (output valid, antialias_enable, input ready);
  modport sink (input valid, antialias_enable, output ready);
endinterface

@@ src/lr_div.sv @@
module lr_div
  import lr_pkg::*;
#(
  parameter int COORD_WIDTH = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [COORD_WIDTH+FRAC_W+1:0] dividend_i,
  input  logic [COORD_WIDTH:0]          divisor_i,
  output logic                          done_o,
  output logic [QUO_W-1:0]              quotient_o
);

  localparam int DW    = COORD_WIDTH + 1;
  localparam int NW    = COORD_WIDTH + FRAC_W + 2;
  localparam int CNT_W = $clog2(QUO_W);

  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    den_q, den_d;
  logic [QUO_W-1:0] shf_q, shf_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;

  logic [DW+1:0] diff;
  logic [DW:0]   shifted;
  logic          qbit;
  logic          last_step;

  // one quotient bit per cycle, the quotient never exceeds QUO_W bits
  assign shifted   = {rem_q, shf_q[QUO_W-1]};
  assign diff      = {1'b0, shifted} - {2'b00, den_q};
  assign qbit      = ~diff[DW+1];
  assign last_step = (cnt_q == CNT_W'(QUO_W - 1));

  assign done_o     = busy_q & last_step;
  assign quotient_o = {shf_q[QUO_W-2:0], qbit};

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    shf_d  = shf_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = dividend_i[NW-1:QUO_W];
      shf_d  = dividend_i[QUO_W-1:0];
      den_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = qbit ? diff[DW-1:0] : shifted[DW-1:0];
      shf_d = {shf_q[QUO_W-2:0], qbit};
      cnt_d = cnt_q + CNT_W'(1);
      if (last_step) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    shf_q <= shf_d;
  end

endmodule

@@ src/line_rasterizer.sv @@
// Line rasterizer. A start item (mode 0) loads two endpoints and the
// background flag and returns nothing; each step item (mode 1) returns the
// pixels of the next column: one pixel for axis-aligned runs and Bresenham
// lines, two or three for antialiased (Wu) lines, the final one marked
// last, and line_end on the final pixel of the line. A step with no line
// left returns a single empty result with line_end and last set.
// Handshake: the input is not ready while an item is in work. A step item
// sends its pixels one at a time, each going out through the result
// register and held back while the receiver is not ready; a start item of
// an antialiased sloped line also waits for the bit-serial gradient divider
// before the input is ready again. The antialias_enable register is
// sampled on each start item.
`include "line_rasterizer_assert.svh"

module line_rasterizer
  import lr_pkg::*;
#(
  parameter int COORD_WIDTH = 10
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  lr_in_if.sink    item_i,
  lr_out_if.source result_o,
  lr_cfg_if.sink   cfg_i
);

  localparam int CW = COORD_WIDTH;
  localparam int MW = CW + 1;
  localparam int EW = CW + 2;
  localparam int IW = CW + FRAC_W + 2;
  localparam int BW = IW - FRAC_W;
  localparam int NW = CW + FRAC_W + 2;

  // ---------------------------------------------------------------
  // line state
  state_e              state_q, state_d;
  kind_e               kind_q, kind_d;
  logic                active_q, active_d;
  logic                swapped_q, swapped_d;
  logic                down_q, down_d;
  logic                diag_q, diag_d;
  logic                bg_q, bg_d;
  logic                aa_q;
  logic [MW-1:0]       major_pos_q, major_pos_d;
  logic [MW-1:0]       major_last_q, major_last_d;
  logic [CW-1:0]       minor_q, minor_d;
  logic [EW-1:0]       err_q, err_d;
  logic [CW-1:0]       mjd_q, mjd_d;
  logic [CW-1:0]       mnd_q, mnd_d;
  logic signed [GRAD_W-1:0] grad_q, grad_d;
  logic signed [IW-1:0]     icpt_q, icpt_d;
  logic [PIDX_W-1:0]   pix_q, pix_d;

  // result register
  logic                    out_valid_q, out_valid_d;
  logic signed [PIX_W-1:0] out_x_q, out_x_d;
  logic signed [PIX_W-1:0] out_y_q, out_y_d;
  logic [INT_W-1:0]        out_int_q, out_int_d;
  logic                    out_bg_q, out_bg_d;
  logic                    out_pv_q, out_pv_d;
  logic                    out_end_q, out_end_d;
  logic                    out_last_q, out_last_d;

  // ---------------------------------------------------------------
  // start setup from the item fields
  logic [CW-1:0] x0, y0, x1, y1;
  logic          is_run, run_sw;
  logic [CW-1:0] ra, rb, rlo, rhi;
  logic [CW-1:0] adx, ady;
  logic          sl_sw;
  logic [CW-1:0] pa, qa, pb, qb, p0, q0, p1, q1;
  logic [CW-1:0] mjd_s, mnd_s;
  logic          down_s;

  always_comb begin
    x0 = item_i.x_start;
    y0 = item_i.y_start;
    x1 = item_i.x_end;
    y1 = item_i.y_end;
    is_run = (x0 == x1) || (y0 == y1);
    run_sw = (x0 == x1);
    ra  = run_sw ? y0 : x0;
    rb  = run_sw ? y1 : x1;
    rlo = (ra > rb) ? rb : ra;
    rhi = (ra > rb) ? ra : rb;
    adx = (x1 > x0) ? x1 - x0 : x0 - x1;
    ady = (y1 > y0) ? y1 - y0 : y0 - y1;
    sl_sw = ady > adx;
    pa = sl_sw ? y0 : x0;
    qa = sl_sw ? x0 : y0;
    pb = sl_sw ? y1 : x1;
    qb = sl_sw ? x1 : y1;
    // walk along increasing major coordinate
    if (pa > pb) begin
      p0 = pb; q0 = qb; p1 = pa; q1 = qa;
    end else begin
      p0 = pa; q0 = qa; p1 = pb; q1 = qb;
    end
    mjd_s  = p1 - p0;
    mnd_s  = (q1 > q0) ? q1 - q0 : q0 - q1;
    down_s = q1 < q0;
  end

  // ---------------------------------------------------------------
  // gradient divider: (2*minor*256 + major) / (2*major)
  logic             item_acc, out_free, emit;
  logic             div_start, div_done;
  logic [NW-1:0]    div_num;
  logic [CW:0]      div_den;
  logic [QUO_W-1:0] div_quo;

  assign item_acc  = item_i.valid & item_i.ready;
  assign div_start = item_acc & ~item_i.mode & ~is_run & aa_q;
  assign div_num   = NW'({mnd_s, {(FRAC_W + 1){1'b0}}}) + NW'(mjd_s);
  assign div_den   = {mjd_s, 1'b0};

  lr_div #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_num),
    .divisor_i (div_den),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // ---------------------------------------------------------------
  // pixel of the current slot
  logic [FRAC_W-1:0]    frac;
  logic [INT_W-1:0]     hi_int;
  logic signed [BW-1:0] base;
  logic [31:0]          maj_w, mnr_w;
  logic [INT_W-1:0]     inten;
  logic [PIDX_W-1:0]    last_idx;
  logic                 is_last, done_col;
  logic [EW-1:0]        err_sub;

  assign frac     = icpt_q[FRAC_W-1:0];
  assign base     = $signed(icpt_q[IW-1:FRAC_W]);
  assign hi_int   = frac + (diag_q ? DIAG_CORR : '0);
  assign last_idx = (kind_q != KIND_WU) ? PIX_MAIN : (diag_q ? PIX_BELOW : PIX_ABOVE);
  assign is_last  = ~active_q | (pix_q == last_idx);
  assign done_col = major_pos_q >= major_last_q;
  assign err_sub  = err_q - EW'(mnd_q);

  always_comb begin
    maj_w = 32'(major_pos_q);
    mnr_w = 32'(minor_q);
    inten = INT_FULL;
    if (kind_q == KIND_WU) begin
      unique case (pix_q)
        PIX_MAIN: begin
          mnr_w = 32'(base);
          inten = INT_FULL - frac;
        end
        PIX_ABOVE: begin
          mnr_w = 32'(base) + 32'd1;
          inten = hi_int;
        end
        default: begin
          mnr_w = 32'(base) - 32'd1;
          inten = hi_int;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------
  // sequencer
  assign out_free = ~out_valid_q | result_o.ready;
  assign emit     = (state_q == ST_EMIT) & out_free;

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    active_d     = active_q;
    swapped_d    = swapped_q;
    down_d       = down_q;
    diag_d       = diag_q;
    bg_d         = bg_q;
    major_pos_d  = major_pos_q;
    major_last_d = major_last_q;
    minor_d      = minor_q;
    err_d        = err_q;
    mjd_d        = mjd_q;
    mnd_d        = mnd_q;
    grad_d       = grad_q;
    icpt_d       = icpt_q;
    pix_d        = pix_q;

    out_valid_d = out_valid_q & ~result_o.ready;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_int_d   = out_int_q;
    out_bg_d    = out_bg_q;
    out_pv_d    = out_pv_q;
    out_end_d   = out_end_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (item_acc) begin
          if (item_i.mode) begin
            pix_d   = PIX_MAIN;
            state_d = ST_EMIT;
          end else begin
            bg_d     = item_i.use_background;
            active_d = 1'b1;
            err_d    = '0;
            grad_d   = '0;
            icpt_d   = '0;
            diag_d   = 1'b0;
            down_d   = 1'b0;
            if (is_run) begin
              kind_d       = KIND_RUN;
              swapped_d    = run_sw;
              major_pos_d  = MW'(rlo);
              major_last_d = MW'(rhi) - MW'(1);
              minor_d      = run_sw ? x0 : y0;
              mjd_d        = rhi - rlo;
              mnd_d        = '0;
              active_d     = (rlo != rhi);
            end else begin
              swapped_d   = sl_sw;
              mjd_d       = mjd_s;
              mnd_d       = mnd_s;
              down_d      = down_s;
              major_pos_d = MW'(p0);
              minor_d     = q0;
              if (!aa_q) begin
                kind_d       = KIND_BRES;
                major_last_d = MW'(p1);
                err_d        = EW'(mjd_s >> 1);
              end else begin
                kind_d       = KIND_WU;
                major_last_d = MW'(p1) - MW'(1);
                diag_d       = (mnd_s == mjd_s);
                state_d      = ST_DIV;
              end
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          grad_d  = down_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
          icpt_d  = IW'($signed({1'b0, minor_q, {FRAC_W{1'b0}}}))
                  + IW'(down_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo}));
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          out_valid_d = 1'b1;
          out_x_d     = active_q ? (swapped_q ? mnr_w[PIX_W-1:0] : maj_w[PIX_W-1:0]) : '0;
          out_y_d     = active_q ? (swapped_q ? maj_w[PIX_W-1:0] : mnr_w[PIX_W-1:0]) : '0;
          out_int_d   = active_q ? inten : '0;
          out_bg_d    = active_q & bg_q;
          out_pv_d    = active_q;
          out_end_d   = ~active_q | (is_last & done_col);
          out_last_d  = is_last;
          if (is_last) begin
            state_d = ST_IDLE;
            pix_d   = PIX_MAIN;
            if (active_q) begin
              major_pos_d = major_pos_q + MW'(1);
              if (done_col) begin
                active_d = 1'b0;
              end
              if (kind_q == KIND_WU) begin
                icpt_d = icpt_q + IW'(grad_q);
              end else if (kind_q == KIND_BRES) begin
                err_d = err_sub;
                // error went negative: step the minor axis
                if (err_sub[EW-1]) begin
                  minor_d = down_q ? minor_q - CW'(1) : minor_q + CW'(1);
                  err_d   = err_sub + EW'(mjd_q);
                end
              end
            end
          end else begin
            pix_d = pix_q + PIDX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kind_q       <= KIND_RUN;
      active_q     <= 1'b0;
      swapped_q    <= 1'b0;
      down_q       <= 1'b0;
      diag_q       <= 1'b0;
      bg_q         <= 1'b0;
      aa_q         <= 1'b0;
      major_pos_q  <= '0;
      major_last_q <= '0;
      minor_q      <= '0;
      err_q        <= '0;
      mjd_q        <= '0;
      mnd_q        <= '0;
      grad_q       <= '0;
      icpt_q       <= '0;
      pix_q        <= PIX_MAIN;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      kind_q       <= kind_d;
      active_q     <= active_d;
      swapped_q    <= swapped_d;
      down_q       <= down_d;
      diag_q       <= diag_d;
      bg_q         <= bg_d;
      major_pos_q  <= major_pos_d;
      major_last_q <= major_last_d;
      minor_q      <= minor_d;
      err_q        <= err_d;
      mjd_q        <= mjd_d;
      mnd_q        <= mnd_d;
      grad_q       <= grad_d;
      icpt_q       <= icpt_d;
      pix_q        <= pix_d;
      out_valid_q  <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        aa_q <= cfg_i.antialias_enable;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_int_q  <= out_int_d;
    out_bg_q   <= out_bg_d;
    out_pv_q   <= out_pv_d;
    out_end_q  <= out_end_d;
    out_last_q <= out_last_d;
  end

  assign item_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready  = 1'b1;

  assign result_o.valid            = out_valid_q;
  assign result_o.pixel_x          = out_x_q;
  assign result_o.pixel_y          = out_y_q;
  assign result_o.intensity        = out_int_q;
  assign result_o.paint_background = out_bg_q;
  assign result_o.pixel_valid      = out_pv_q;
  assign result_o.line_end         = out_end_q;
  assign result_o.last             = out_last_q;

  // ---------------------------------------------------------------
  `LR_ASSERT_IMP(a_end_is_last, clk_i, rst_ni, out_valid_q && out_end_q, out_last_q)
  `LR_ASSERT_IMP(a_empty_result, clk_i, rst_ni, out_valid_q && !out_pv_q,
                 out_end_q && out_last_q && (out_int_q == '0) && !out_bg_q)
  `LR_ASSERT_NXT(a_div_returns, clk_i, rst_ni, div_done, state_q == ST_IDLE)
  `LR_ASSERT_IMP(a_diag_wu_only, clk_i, rst_ni, active_q && diag_q,
                 (kind_q == KIND_WU) && (mnd_q == mjd_q))

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top
  import lr_pkg::*;
;

  localparam int COORD_W      = 10;
  localparam int COORD_MAX    = (1 << COORD_W) - 1;
  localparam int ITEM_TARGET  = 360;
  localparam int PHASE_ITEMS  = 60;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 300000;

  typedef enum bit {
    MODE_START = 1'b0,
    MODE_STEP  = 1'b1
  } mode_e;

  typedef struct {
    mode_e             mode;
    bit [COORD_W-1:0]  xs;
    bit [COORD_W-1:0]  ys;
    bit [COORD_W-1:0]  xe;
    bit [COORD_W-1:0]  ye;
    bit                bg;
  } line_cmd_t;

  typedef struct {
    logic signed [PIX_W-1:0] px;
    logic signed [PIX_W-1:0] py;
    logic [INT_W-1:0]        inten;
    logic                    bg;
    logic                    pvalid;
    logic                    lend;
    logic                    last;
  } pixel_t;

  class raster_scoreboard;
    pixel_t      pending_pixels[$];
    int unsigned errors;
    bit          aa_en;
    bit          active;
    kind_e       kind;
    bit          swapped;
    bit          step_down;
    bit          diag;
    bit          bg_flag;
    longint      maj_pos, maj_last, mnr_pos, err_acc;
    longint      maj_d, mnr_d, grad, icept;

    function new();
      errors = 0;
      aa_en = 0;
      active = 0;
      kind = KIND_RUN;
      swapped = 0;
      step_down = 0;
      diag = 0;
      bg_flag = 0;
      maj_pos = 0;
      maj_last = 0;
      mnr_pos = 0;
      err_acc = 0;
      maj_d = 0;
      mnr_d = 0;
      grad = 0;
      icept = 0;
    endfunction

    function void set_antialias(bit v);
      aa_en = v;
    endfunction

    function longint absdelta(longint a, longint b);
      return (a > b) ? a - b : b - a;
    endfunction

    function pixel_t make_pixel(longint maj, longint mnr, longint inten);
      pixel_t p;
      longint px, py;
      px = swapped ? mnr : maj;
      py = swapped ? maj : mnr;
      p.px = px[PIX_W-1:0];
      p.py = py[PIX_W-1:0];
      p.inten = inten[INT_W-1:0];
      p.bg = bg_flag;
      p.pvalid = 1'b1;
      p.lend = 1'b0;
      p.last = 1'b0;
      return p;
    endfunction

    function void load_line(longint x0, longint y0, longint x1, longint y1);
      longint t, a, b, mag;
      active = 1;
      err_acc = 0;
      grad = 0;
      icept = 0;
      diag = 0;
      step_down = 0;
      if (x0 == x1 || y0 == y1) begin
        kind = KIND_RUN;
        swapped = (x0 == x1);
        a = swapped ? y0 : x0;
        b = swapped ? y1 : x1;
        if (a > b) begin
          t = a; a = b; b = t;
        end
        maj_pos = a;
        maj_last = b - 1;
        mnr_pos = swapped ? x0 : y0;
        maj_d = b - a;
        mnr_d = 0;
        if (a == b) active = 0;
        return;
      end
      swapped = absdelta(y1, y0) > absdelta(x1, x0);
      if (swapped) begin
        t = x0; x0 = y0; y0 = t;
        t = x1; x1 = y1; y1 = t;
      end
      if (x0 > x1) begin
        t = x0; x0 = x1; x1 = t;
        t = y0; y0 = y1; y1 = t;
      end
      maj_d = x1 - x0;
      mnr_d = absdelta(y1, y0);
      step_down = (y1 < y0);
      maj_pos = x0;
      mnr_pos = y0;
      if (!aa_en) begin
        kind = KIND_BRES;
        maj_last = x1;
        err_acc = maj_d / 2;
      end else begin
        // gradient in 256ths, rounded half away from zero
        mag = (2 * mnr_d * 256 + maj_d) / (2 * maj_d);
        kind = KIND_WU;
        maj_last = x1 - 1;
        grad = step_down ? -mag : mag;
        icept = y0 * 256 + grad;
        diag = (mnr_d == maj_d);
      end
    endfunction

    function void predict_column();
      pixel_t col[3];
      int     n;
      longint frac, base, hi;
      bit     done;
      n = 0;
      if (!active) begin
        col[0] = make_pixel(0, 0, 0);
        col[0].px = '0;
        col[0].py = '0;
        col[0].bg = 1'b0;
        col[0].pvalid = 1'b0;
        col[0].lend = 1'b1;
        col[0].last = 1'b1;
        pending_pixels.push_back(col[0]);
        return;
      end
      if (kind == KIND_WU) begin
        frac = icept & 255;
        base = icept >>> 8;
        hi = (frac + (diag ? longint'(DIAG_CORR) : 0)) & 255;
        col[n++] = make_pixel(maj_pos, base, 255 - frac);
        col[n++] = make_pixel(maj_pos, base + 1, hi);
        if (diag) col[n++] = make_pixel(maj_pos, base - 1, hi);
        icept += grad;
      end else begin
        col[n++] = make_pixel(maj_pos, mnr_pos, longint'(INT_FULL));
        if (kind == KIND_BRES) begin
          err_acc -= mnr_d;
          if (err_acc < 0) begin
            mnr_pos += step_down ? -1 : 1;
            err_acc += maj_d;
          end
        end
      end
      done = (maj_pos >= maj_last);
      maj_pos++;
      if (done) begin
        active = 0;
        col[n-1].lend = 1'b1;
      end
      col[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) pending_pixels.push_back(col[i]);
    endfunction

    function void note_item(line_cmd_t c);
      if (c.mode == MODE_START) begin
        bg_flag = c.bg;
        load_line(c.xs, c.ys, c.xe, c.ye);
      end else begin
        predict_column();
      end
    endfunction

    function void cmp_field(string name, logic signed [31:0] expv, logic signed [31:0] gotv);
      if (gotv !== expv) begin
        $error("%s: expected %0d, got %0d", name, expv, gotv);
        errors++;
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t exp_p;
      if (pending_pixels.size() == 0) begin
        $error("result with no expected pixel: x %0d y %0d", got.px, got.py);
        errors++;
        return;
      end
      exp_p = pending_pixels.pop_front();
      cmp_field("pixel_x", exp_p.px, got.px);
      cmp_field("pixel_y", exp_p.py, got.py);
      cmp_field("intensity", exp_p.inten, got.inten);
      cmp_field("paint_background", exp_p.bg, got.bg);
      cmp_field("pixel_valid", exp_p.pvalid, got.pvalid);
      cmp_field("line_end", exp_p.lend, got.lend);
      cmp_field("last", exp_p.last, got.last);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  lr_in_if #(.COORD_WIDTH(COORD_W)) item_if ();
  lr_out_if                         result_if ();
  lr_cfg_if                         cfg_if ();

  line_rasterizer #(
    .COORD_WIDTH(COORD_W)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(result_if),
    .cfg_i   (cfg_if)
  );

  raster_scoreboard sb = new();

  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  bit          aa_now       = 0;
  bit          calm         = 0;
  bit          hold_off     = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // monitors: sample handshakes at the rising edge
  always @(posedge clk_i) begin
    line_cmd_t c;
    pixel_t    p;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) sb.set_antialias(cfg_if.antialias_enable);
      if (item_if.valid && item_if.ready) begin
        c.mode = mode_e'(item_if.mode);
        c.xs = item_if.x_start;
        c.ys = item_if.y_start;
        c.xe = item_if.x_end;
        c.ye = item_if.y_end;
        c.bg = item_if.use_background;
        sb.note_item(c);
      end
      if (result_if.valid && result_if.ready) begin
        p.px = result_if.pixel_x;
        p.py = result_if.pixel_y;
        p.inten = result_if.intensity;
        p.bg = result_if.paint_background;
        p.pvalid = result_if.pixel_valid;
        p.lend = result_if.line_end;
        p.last = result_if.last;
        sb.check_pixel(p);
        results_seen++;
      end
    end
  end

  // receiver side stalls
  initial begin
    int stall;
    int r;
    stall = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off || !rst_ni) begin
        result_if.ready = 1'b0;
      end else if (stall > 0) begin
        result_if.ready = 1'b0;
        stall--;
      end else if (calm) begin
        result_if.ready = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          result_if.ready = 1'b1;
        end else begin
          result_if.ready = 1'b0;
          stall = (r < 94) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end
      end
    end
  end

  // one long back-pressure stretch so the block fills and stalls its input
  initial begin
    wait (results_seen >= 100);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_item(line_cmd_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_if.valid = 1'b1;
    item_if.mode = c.mode;
    item_if.x_start = c.xs;
    item_if.y_start = c.ys;
    item_if.x_end = c.xe;
    item_if.y_end = c.ye;
    item_if.use_background = c.bg;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic push_start(int x0, int y0, int x1, int y1, bit bg);
    line_cmd_t c;
    c.mode = MODE_START;
    c.xs = x0[COORD_W-1:0];
    c.ys = y0[COORD_W-1:0];
    c.xe = x1[COORD_W-1:0];
    c.ye = y1[COORD_W-1:0];
    c.bg = bg;
    push_item(c);
  endtask

  // coordinate fields of a step item are don't-care, so fill them with noise
  task automatic push_steps(int n);
    line_cmd_t c;
    repeat (n) begin
      c.mode = MODE_STEP;
      c.xs = COORD_W'($urandom_range(0, COORD_MAX));
      c.ys = COORD_W'($urandom_range(0, COORD_MAX));
      c.xe = COORD_W'($urandom_range(0, COORD_MAX));
      c.ye = COORD_W'($urandom_range(0, COORD_MAX));
      c.bg = bit'($urandom_range(0, 1));
      push_item(c);
    end
  endtask

  task automatic write_antialias(bit v);
    cfg_if.antialias_enable = v;
    cfg_if.valid = 1'b1;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
    aa_now = v;
  endtask

  // a start item can still be busy in the divider after the last pixel
  task automatic drain();
    item_if.valid = 1'b0;
    while (sb.pending_pixels.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic random_sequence();
    int x0, y0, x1, y1, dx, dy, adx, ady, cols, n, shape;
    x0 = $urandom_range(0, COORD_MAX);
    y0 = $urandom_range(0, COORD_MAX);
    shape = $urandom_range(0, 19);
    if (shape == 0) begin
      // stray steps, usually on a finished line
      push_steps($urandom_range(1, 3));
      return;
    end
    if (shape == 1) begin
      x1 = $urandom_range(0, COORD_MAX);
      y1 = $urandom_range(0, COORD_MAX);
    end else begin
      dx = int'($urandom_range(0, 24)) - 12;
      dy = int'($urandom_range(0, 24)) - 12;
      if (shape == 2) dx = 0;
      else if (shape == 3) dy = 0;
      else if (shape == 4) dy = $urandom_range(0, 1) ? dx : -dx;
      x1 = x0 + dx;
      if (x1 < 0 || x1 > COORD_MAX) x1 = x0 - dx;
      y1 = y0 + dy;
      if (y1 < 0 || y1 > COORD_MAX) y1 = y0 - dy;
    end
    adx = (x1 > x0) ? x1 - x0 : x0 - x1;
    ady = (y1 > y0) ? y1 - y0 : y0 - y1;
    if (adx == 0 || ady == 0) cols = adx + ady;
    else cols = ((adx > ady) ? adx : ady) + (aa_now ? 0 : 1);
    n = cols + $urandom_range(0, 2);
    // sometimes cut the line short; the next start drops it
    if ($urandom_range(0, 4) == 0 || n > 30) n = $urandom_range(0, (n < 30) ? n : 30);
    push_start(x0, y0, x1, y1, bit'($urandom_range(0, 1)));
    push_steps(n);
  endtask

  initial begin
    int          phase;
    int unsigned phase_start;
    rst_ni = 1'b0;
    item_if.valid = 1'b0;
    item_if.mode = MODE_START;
    item_if.x_start = '0;
    item_if.y_start = '0;
    item_if.x_end = '0;
    item_if.y_end = '0;
    item_if.use_background = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.antialias_enable = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // plain drawing, antialias off out of reset
    push_steps(1);
    push_start(7, 1023, 7, 1021, 1'b1);
    push_steps(3);
    push_start(1023, 0, 1021, 0, 1'b0);
    push_steps(2);
    push_start(512, 512, 512, 512, 1'b1);
    push_steps(1);
    push_start(0, 1023, 2, 1018, 1'b0);
    push_steps(2);
    // restart in the middle of a line
    push_start(1023, 0, 1018, 2, 1'b1);
    push_steps(2);
    drain();

    // antialiased: diagonals reaching one past the canvas, and a steep line
    write_antialias(1'b1);
    push_start(0, 1020, 3, 1023, 1'b0);
    push_steps(4);
    push_start(3, 0, 0, 3, 1'b1);
    push_steps(3);
    push_start(1, 0, 0, 5, 1'b0);
    push_steps(2);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      drain();
      write_antialias((phase < 2) ? phase[0] : bit'($urandom_range(0, 1)));
      calm = ($urandom_range(0, 3) == 0);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEM_TARGET)
        random_sequence();
      phase++;
    end
    calm = 1'b0;
    drain();

    if (sb.errors == 0 && sb.pending_pixels.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
